@@ design/pid_speed_to_pwm_duty_defines.svh @@
// Assertion macros shared by the checker of the speed controller.
`ifndef PID_SPEED_TO_PWM_DUTY_DEFINES_SVH
`define PID_SPEED_TO_PWM_DUTY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pspd_pkg.sv @@
`timescale 1ns / 1ps

package pspd_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] REG_KP         = 3'd0;
    localparam logic [2:0] REG_KI         = 3'd1;
    localparam logic [2:0] REG_KD         = 3'd2;
    localparam logic [2:0] REG_TARGET     = 3'd3;
    localparam logic [2:0] REG_FULL_SCALE = 3'd4;

    localparam logic [15:0]        KP_RESET         = 16'd256;
    localparam logic [15:0]        KI_RESET         = 16'd26;
    localparam logic [15:0]        KD_RESET         = 16'd3;
    localparam logic signed [15:0] TARGET_RESET     = 16'sd100;
    localparam logic [14:0]        FULL_SCALE_RESET = 15'd100;

    localparam logic [7:0] DUTY_MAX = 8'd255;
    localparam logic [2:0] DIV_LAST = 3'd7;

    typedef struct packed {
        logic [15:0]        kp;
        logic [15:0]        ki;
        logic [15:0]        kd;
        logic signed [15:0] target;
        logic [14:0]        full_scale;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TERMS,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_SUM,
        S_DRIVE,
        S_DIV,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     load_meas;
        logic     terms;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     drive_load;
        logic     div_step;
        logic     out_load;
    } cmd_t;

endpackage

@@ design/pid_speed_to_pwm_duty.sv @@
`timescale 1ns / 1ps
// Items are processed one at a time: meas_stall is high from acceptance until the result
// is loaded into the output registers, through the shared multiplier sequence for the
// P, I and D terms and the restoring divider that forms the duty.
// Reset (rst_n low, asynchronous) clears the integral and previous error, returns
// the gains, setpoint and full scale to their defaults and empties the output.

module pid_speed_to_pwm_duty
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pspd_pkg::ADDR_W-1:0]   paddr,
    input  logic [pspd_pkg::DATA_W-1:0]   pwdata,
    output logic [pspd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          meas_valid,
    output logic                          meas_stall,
    input  logic signed [15:0]            measured_speed,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [15:0]            drive_value,
    output logic [7:0]                    pwm_duty
);

    pspd_pkg::cfg_t cfg_reg;
    pspd_pkg::cmd_t cmd;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp         <= pspd_pkg::KP_RESET;
            cfg_reg.ki         <= pspd_pkg::KI_RESET;
            cfg_reg.kd         <= pspd_pkg::KD_RESET;
            cfg_reg.target     <= pspd_pkg::TARGET_RESET;
            cfg_reg.full_scale <= pspd_pkg::FULL_SCALE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                pspd_pkg::REG_KP:         cfg_reg.kp         <= pwdata[15:0];
                pspd_pkg::REG_KI:         cfg_reg.ki         <= pwdata[15:0];
                pspd_pkg::REG_KD:         cfg_reg.kd         <= pwdata[15:0];
                pspd_pkg::REG_TARGET:     cfg_reg.target     <= pwdata[15:0];
                pspd_pkg::REG_FULL_SCALE: cfg_reg.full_scale <= pwdata[14:0];
                default:                  cfg_reg.kp         <= cfg_reg.kp;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pspd_pkg::REG_KP:         prdata = {16'b0, cfg_reg.kp};
            pspd_pkg::REG_KI:         prdata = {16'b0, cfg_reg.ki};
            pspd_pkg::REG_KD:         prdata = {16'b0, cfg_reg.kd};
            pspd_pkg::REG_TARGET:     prdata = {16'b0, cfg_reg.target};
            pspd_pkg::REG_FULL_SCALE: prdata = {17'b0, cfg_reg.full_scale};
            default:                  prdata = '0;
        endcase
    end

    pspd_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .meas_valid   (meas_valid),
        .result_stall (result_stall),
        .meas_stall   (meas_stall),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    pspd_dpath u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .measured_speed (measured_speed),
        .drive_value    (drive_value),
        .pwm_duty       (pwm_duty)
    );

endmodule

@@ design/pspd_ctrl.sv @@
`timescale 1ns / 1ps

module pspd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              meas_valid,
    input  logic              result_stall,
    output logic              meas_stall,
    output logic              result_valid,
    output pspd_pkg::cmd_t    cmd
);

    pspd_pkg::state_t state_reg;
    pspd_pkg::state_t state_next;
    logic [2:0]       cnt_reg;
    logic [2:0]       cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free     = !out_valid_reg || !result_stall;
    assign meas_stall   = (state_reg != pspd_pkg::S_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pspd_pkg::S_IDLE:
            begin
                if (meas_valid)
                begin
                    state_next = pspd_pkg::S_TERMS;
                end
            end
            pspd_pkg::S_TERMS: state_next = pspd_pkg::S_MUL_P;
            pspd_pkg::S_MUL_P: state_next = pspd_pkg::S_MUL_I;
            pspd_pkg::S_MUL_I: state_next = pspd_pkg::S_MUL_D;
            pspd_pkg::S_MUL_D: state_next = pspd_pkg::S_SUM;
            pspd_pkg::S_SUM:   state_next = pspd_pkg::S_DRIVE;
            pspd_pkg::S_DRIVE: state_next = pspd_pkg::S_DIV;
            pspd_pkg::S_DIV:
            begin
                if (cnt_reg == pspd_pkg::DIV_LAST)
                begin
                    state_next = pspd_pkg::S_OUT;
                end
            end
            pspd_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = pspd_pkg::S_IDLE;
                end
            end
            default: state_next = pspd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = pspd_pkg::MUL_P;
        cmd.acc_op   = pspd_pkg::ACC_HOLD;
        unique case (state_reg)
            pspd_pkg::S_IDLE:  cmd.load_meas = meas_valid;
            pspd_pkg::S_TERMS: cmd.terms = 1'b1;
            pspd_pkg::S_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pspd_pkg::MUL_P;
            end
            pspd_pkg::S_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pspd_pkg::MUL_I;
                cmd.acc_op  = pspd_pkg::ACC_LOAD;
            end
            pspd_pkg::S_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pspd_pkg::MUL_D;
                cmd.acc_op  = pspd_pkg::ACC_ADD;
            end
            pspd_pkg::S_SUM:   cmd.acc_op = pspd_pkg::ACC_ADD;
            pspd_pkg::S_DRIVE: cmd.drive_load = 1'b1;
            pspd_pkg::S_DIV:   cmd.div_step = 1'b1;
            pspd_pkg::S_OUT:   cmd.out_load = out_free;
            default:           cmd.load_meas = 1'b0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == pspd_pkg::S_DRIVE)
        begin
            cnt_next = '0;
        end
        else if (state_reg == pspd_pkg::S_DIV)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
    end

    assign out_valid_next = cmd.out_load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pspd_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/pspd_dpath.sv @@
`timescale 1ns / 1ps

module pspd_dpath
(
    input  logic               clk,
    input  logic               rst_n,
    input  pspd_pkg::cfg_t     cfg,
    input  pspd_pkg::cmd_t     cmd,
    input  logic signed [15:0] measured_speed,
    output logic signed [15:0] drive_value,
    output logic [7:0]         pwm_duty
);

    function automatic logic signed [15:0] sat17(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v[16] != v[15])
        begin
            r = v[16] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic signed [15:0] meas_reg;
    logic signed [15:0] err_reg;
    logic signed [15:0] esum_reg;
    logic signed [15:0] last_err_reg;
    logic signed [15:0] deriv_reg;
    logic signed [32:0] prod_reg;
    logic signed [34:0] acc_reg;
    logic               zero_reg;
    logic               fs_zero_reg;
    logic [22:0]        rem_reg;
    logic [21:0]        dvs_reg;
    logic [7:0]         quo_reg;
    logic signed [15:0] drive_reg;
    logic signed [15:0] drive_out_reg;
    logic [7:0]         duty_out_reg;

    logic signed [15:0] err_now;
    logic signed [15:0] esum_next;
    logic signed [15:0] deriv_next;
    logic [15:0]        mul_a;
    logic signed [15:0] mul_b;
    logic signed [34:0] prod_ext;
    logic signed [26:0] shifted;
    logic signed [15:0] drive_sat;
    logic [14:0]        d_clamp;
    logic [22:0]        dvs_ext;
    logic               rem_ge;

    assign err_now    = sat17(17'(cfg.target) - 17'(meas_reg));
    assign esum_next  = sat17(17'(esum_reg) + 17'(err_now));
    assign deriv_next = sat17(17'(err_now) - 17'(last_err_reg));

    always_comb
    begin
        case (cmd.mul_sel)
            pspd_pkg::MUL_I:
            begin
                mul_a = cfg.ki;
                mul_b = esum_reg;
            end
            pspd_pkg::MUL_D:
            begin
                mul_a = cfg.kd;
                mul_b = deriv_reg;
            end
            default:
            begin
                mul_a = cfg.kp;
                mul_b = err_reg;
            end
        endcase
    end

    assign prod_ext = {{2{prod_reg[32]}}, prod_reg};
    assign shifted  = acc_reg[34:8];

    always_comb
    begin
        if (shifted[26:15] == {12{shifted[26]}})
        begin
            drive_sat = shifted[15:0];
        end
        else
        begin
            drive_sat = shifted[26] ? 16'sh8000 : 16'sh7fff;
        end
    end

    assign d_clamp = (drive_sat[14:0] > cfg.full_scale) ? cfg.full_scale : drive_sat[14:0];
    assign dvs_ext = {1'b0, dvs_reg};
    assign rem_ge  = (rem_reg >= dvs_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esum_reg     <= '0;
            last_err_reg <= '0;
        end
        else if (cmd.terms)
        begin
            esum_reg     <= esum_next;
            last_err_reg <= err_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_meas)
        begin
            meas_reg <= measured_speed;
        end
        if (cmd.terms)
        begin
            err_reg   <= err_now;
            deriv_reg <= deriv_next;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= $signed({1'b0, mul_a}) * mul_b;
        end
        case (cmd.acc_op)
            pspd_pkg::ACC_LOAD: acc_reg <= prod_ext;
            pspd_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:            acc_reg <= acc_reg;
        endcase
        if (cmd.drive_load)
        begin
            drive_reg   <= drive_sat;
            zero_reg    <= drive_sat[15] || (drive_sat == 16'sd0);
            fs_zero_reg <= (cfg.full_scale == 15'd0);
            rem_reg     <= {d_clamp, 8'b0} - {8'b0, d_clamp};
            dvs_reg     <= {cfg.full_scale, 7'b0};
            quo_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dvs_ext;
            end
            quo_reg <= {quo_reg[6:0], rem_ge};
            dvs_reg <= dvs_reg >> 1;
        end
        if (cmd.out_load)
        begin
            drive_out_reg <= drive_reg;
            if (zero_reg)
            begin
                duty_out_reg <= '0;
            end
            else if (fs_zero_reg)
            begin
                duty_out_reg <= pspd_pkg::DUTY_MAX;
            end
            else
            begin
                duty_out_reg <= quo_reg;
            end
        end
    end

    assign drive_value = drive_out_reg;
    assign pwm_duty    = duty_out_reg;

endmodule

@@ design/pspd_checker.sv @@
`timescale 1ns / 1ps
`include "pid_speed_to_pwm_duty_defines.svh"

module pspd_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               meas_valid,
    input logic               meas_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [15:0] drive_value,
    input logic [7:0]         pwm_duty
);

    // Once an item is taken the block is busy until its result is formed.
    `PSPD_ASSERT_NEXT(busy_after_accept, meas_valid && !meas_stall, meas_stall, "no busy after item")

    // A new result appears only at the end of a busy period.
    `PSPD_ASSERT_NOW(result_from_busy, $rose(result_valid), $past(meas_stall), "result while idle")

    // A drive that is not positive gives zero duty.
    `PSPD_ASSERT_NOW(duty_zero_for_low_drive, result_valid && (drive_value <= 16'sd0), pwm_duty == 8'd0, "duty for low drive")

    `PSPD_ASSERT_NEXT(result_held, result_valid && result_stall, result_valid && $stable(drive_value) && $stable(pwm_duty), "stalled result changed")

endmodule

bind pid_speed_to_pwm_duty pspd_checker u_pspd_checker (.*);

@@ tb/sv/pid_speed_to_pwm_duty_test.sv @@
`timescale 1ns / 1ps

module pid_speed_to_pwm_duty_test;

    localparam int unsigned RANDOM_ITEMS = 1950;
    localparam int unsigned QUIET_ITEMS  = 200;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_MID   = 3'd6;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    typedef struct {
        logic signed [15:0] drive;
        logic [7:0]         duty;
    } pid_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [pspd_pkg::ADDR_W-1:0]   paddr;
    logic [pspd_pkg::DATA_W-1:0]   pwdata;
    logic [pspd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          meas_valid;
    logic                          meas_stall;
    logic signed [15:0]            measured_speed;
    logic                          result_valid;
    logic                          result_stall;
    logic signed [15:0]            drive_value;
    logic [7:0]                    pwm_duty;

    logic [15:0]         gain_p;
    logic [15:0]         gain_i;
    logic [15:0]         gain_d;
    logic signed [15:0]  setpoint;
    logic [14:0]         full_scale_q;
    logic signed [15:0]  integral_acc;
    logic signed [15:0]  previous_err;

    pid_result_t         expected_results[$];
    int unsigned         mismatch_count;
    int unsigned         cycle_count;
    bit                  quiet_mode;

    pid_speed_to_pwm_duty u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .meas_valid     (meas_valid),
        .meas_stall     (meas_stall),
        .measured_speed (measured_speed),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .drive_value    (drive_value),
        .pwm_duty       (pwm_duty)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint clip16(input longint v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic pid_result_t compute_drive(input logic signed [15:0] speed);
        longint      kp;
        longint      ki;
        longint      kd;
        longint      fs;
        longint      tgt;
        longint      meas;
        longint      err;
        longint      deriv;
        longint      sum;
        longint      drv;
        longint      clamped;
        longint      duty;
        pid_result_t r;
        kp   = gain_p;
        ki   = gain_i;
        kd   = gain_d;
        fs   = full_scale_q;
        tgt  = setpoint;
        meas = speed;
        err  = clip16(tgt - meas);
        integral_acc = 16'(clip16(longint'(integral_acc) + err));
        deriv = clip16(err - longint'(previous_err));
        previous_err = 16'(err);
        sum = kp * err + ki * longint'(integral_acc) + kd * deriv;
        drv = clip16(sum >>> 8);
        if (drv <= 0)
        begin
            duty = 0;
        end
        else if (fs == 0)
        begin
            duty = 255;
        end
        else
        begin
            clamped = (drv > fs) ? fs : drv;
            duty = (clamped * 255) / fs;
        end
        r.drive = 16'(drv);
        r.duty  = 8'(duty);
        return r;
    endfunction

    initial
    begin
        int unsigned burst;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet_mode && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 6);
                result_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        pid_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: drive_value %0d, pwm_duty %0d", drive_value, pwm_duty);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (drive_value !== want.drive)
                begin
                    $error("drive_value: expected %0d, got %0d", want.drive, drive_value);
                    mismatch_count++;
                end
                if (pwm_duty !== want.duty)
                begin
                    $error("pwm_duty: expected %0d, got %0d", want.duty, pwm_duty);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_speed(input logic signed [15:0] speed);
        int unsigned gap;
        gap = 0;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
        end
        if (gap != 0)
        begin
            @(negedge clk);
            meas_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        meas_valid     <= 1'b1;
        measured_speed <= speed;
        @(posedge clk);
        while (meas_stall)
        begin
            @(posedge clk);
        end
        expected_results.push_back(compute_drive(speed));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        meas_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        logic [31:0] data;
        data = $urandom();
        data[15:0] = value;
        if (index == pspd_pkg::REG_FULL_SCALE)
        begin
            data[15] = 1'($urandom_range(0, 1));
        end
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (index)
            pspd_pkg::REG_KP:         gain_p       = data[15:0];
            pspd_pkg::REG_KI:         gain_i       = data[15:0];
            pspd_pkg::REG_KD:         gain_d       = data[15:0];
            pspd_pkg::REG_TARGET:     setpoint     = data[15:0];
            pspd_pkg::REG_FULL_SCALE: full_scale_q = data[14:0];
            default:                  ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_gains(input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd);
        write_register(pspd_pkg::REG_KP, kp);
        write_register(pspd_pkg::REG_KI, ki);
        write_register(pspd_pkg::REG_KD, kd);
    endtask

    task automatic test_default_settings();
        send_speed(16'sd0);
        send_speed(16'sd100);
        send_speed(16'sd50);
        send_speed(16'sd150);
    endtask

    task automatic test_error_saturation();
        wait_idle();
        write_register(pspd_pkg::REG_TARGET, 16'h7FFF);
        send_speed(-16'sd32768);
        send_speed(-16'sd32768);
        wait_idle();
        write_register(pspd_pkg::REG_TARGET, 16'h8000);
        send_speed(16'sd32767);
    endtask

    task automatic test_gain_extremes();
        wait_idle();
        write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_register(pspd_pkg::REG_FULL_SCALE, 16'h7FFF);
        write_register(pspd_pkg::REG_TARGET, 16'h0000);
        send_speed(16'sd1);
        send_speed(-16'sd1);
        send_speed(16'sd32767);
        wait_idle();
        write_gains(16'h0000, 16'h0000, 16'h0000);
        send_speed(16'sd12345);
        wait_idle();
        write_gains(16'h0001, 16'h0000, 16'h0000);
        send_speed(16'sd1);
        send_speed(-16'sd1);
    endtask

    task automatic test_full_scale_limits();
        wait_idle();
        write_gains(16'h0100, 16'h0000, 16'h0000);
        write_register(pspd_pkg::REG_TARGET, 16'h0000);
        write_register(pspd_pkg::REG_FULL_SCALE, 16'h0001);
        send_speed(-16'sd1);
        send_speed(16'sd0);
        wait_idle();
        write_register(pspd_pkg::REG_FULL_SCALE, 16'h0000);
        send_speed(-16'sd5);
        send_speed(16'sd5);
        wait_idle();
        write_register(pspd_pkg::REG_FULL_SCALE, 16'h7FFF);
        send_speed(-16'sd32767);
        send_speed(-16'sd20000);
    endtask

    task automatic test_unused_addresses();
        wait_idle();
        write_register(REG_SPARE_FIRST, 16'($urandom()));
        write_register(REG_SPARE_MID, 16'($urandom()));
        write_register(REG_SPARE_LAST, 16'($urandom()));
        send_speed(16'($urandom()));
        send_speed(16'($urandom()));
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom());
            default: return 16'($urandom_range(0, 1024));
        endcase
    endfunction

    function automatic logic [15:0] pick_full_scale();
        case ($urandom_range(0, 15))
            0:       return 16'h7FFF;
            1:       return 16'h0001;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(1, 32767));
            default: return 16'($urandom_range(1, 1000));
        endcase
    endfunction

    function automatic logic [15:0] pick_setpoint();
        int value;
        case ($urandom_range(0, 7))
            0:       value = -32768;
            1:       value = 32767;
            2:       value = int'($urandom());
            default: value = int'($urandom_range(0, 2000)) - 1000;
        endcase
        return 16'(value);
    endfunction

    function automatic logic signed [15:0] next_speed();
        int span;
        int offset;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                return 16'($urandom());
            end
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       return -16'sd32768;
                    1:       return 16'sd32767;
                    2:       return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
            9:
            begin
                return setpoint;
            end
            default:
            begin
                span = ($urandom_range(0, 3) == 0) ? 2000 : 40;
                offset = int'($urandom_range(0, 2 * span)) - span;
                return 16'(clip16(longint'(setpoint) + longint'(offset)));
            end
        endcase
    endfunction

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned run_len;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            if (RANDOM_ITEMS - sent <= QUIET_ITEMS)
            begin
                quiet_mode = 1'b1;
            end
            write_gains(pick_gain(), pick_gain(), pick_gain());
            write_register(pspd_pkg::REG_TARGET, pick_setpoint());
            write_register(pspd_pkg::REG_FULL_SCALE, pick_full_scale());
            if ($urandom_range(0, 7) == 0)
            begin
                write_register(REG_SPARE_FIRST, 16'($urandom()));
            end
            run_len = $urandom_range(40, 160);
            if (run_len > RANDOM_ITEMS - sent)
            begin
                run_len = RANDOM_ITEMS - sent;
            end
            repeat (run_len)
            begin
                send_speed(next_speed());
            end
            sent += run_len;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        meas_valid     = 1'b0;
        measured_speed = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        quiet_mode     = 1'b0;
        gain_p         = pspd_pkg::KP_RESET;
        gain_i         = pspd_pkg::KI_RESET;
        gain_d         = pspd_pkg::KD_RESET;
        setpoint       = pspd_pkg::TARGET_RESET;
        full_scale_q   = pspd_pkg::FULL_SCALE_RESET;
        integral_acc   = '0;
        previous_err   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_settings();
        test_error_saturation();
        test_gain_extremes();
        test_full_scale_limits();
        test_unused_addresses();
        test_random_traffic();

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/pspd_pkg.sv
design/pspd_ctrl.sv
design/pspd_dpath.sv
design/pid_speed_to_pwm_duty.sv
design/pspd_checker.sv
tb/sv/pid_speed_to_pwm_duty_test.sv
